@@ rtl/bb3_pkg.sv @@
// Package for the 3x3 box blur line stream unit.
// Holds sizes, codes, payload structs and the constants shared by all modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  // Largest line the line store holds.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  // Width in use spans 3..MAX_WIDTH, so it needs one bit more than a column.
  localparam int W_W       = COL_W + 1;

  localparam int PIX_W     = 8;
  localparam int LS_W      = 2 * PIX_W;
  // Nine pixels of 255 sum to 2295.
  localparam int SUM_W     = 12;

  localparam int WIDTH_W   = 11;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 11'd3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Division by nine: floor(sum * 7282 / 2^16) is exact for sum below 2296.
  localparam int DIV9_SHIFT = 16;
  localparam int RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int PROD_W     = SUM_W + RECIP_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE  = 2'd1;

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue at the output.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Which input line of the stream is running.
  typedef enum logic [2:0] {
    PH_LINE0  = 3'b001,
    PH_LINE1  = 3'b010,
    PH_STEADY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             stream_end;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             line_end;
    logic             stream_end_out;
  } out_t;

  // One classified word as the front hands it to the back.
  typedef struct packed {
    logic             is_end;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             emit_a;  // one pixel result for the previous column
    logic             a_sum;   // that result carries the filtered value, else zero
    logic             emit_b;  // zero pixel that closes the output line
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    phase_t           phase;
  } front_stat_t;

  // Second back stage: the window sum and what to emit.
  typedef struct packed {
    logic             is_end;
    logic             emit_a;
    logic             a_sum;
    logic             emit_b;
    logic [SUM_W-1:0] sum;
  } exec_t;

endpackage

`default_nettype wire

@@ rtl/box_blur_3x3_line_stream_unit.sv @@
// Path: command queue, stages one and two, result queue. Throughput: one pixel word
// per cycle when not stalled, set by the single line store read and write per
// pixel; the last column yields two result words, drained one per cycle.
// Reset: rst_n is synchronous, active low; it clears counters, window and queues.
// The line store has no clearing pass; its entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_line_stream_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bb3_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bb3_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::WIDTH_W-1:0]   cfg_data
);
  import bb3_pkg::*;

  // Configuration registers. Writes are taken in any cycle; the user writes
  // them only while the block is idle. Unknown indexes are ignored.
  logic [WIDTH_W-1:0] line_width_r;
  logic               normalize_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_RESET;
      normalize_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width_r <= cfg_data;
        CFG_NORMALIZE:  normalize_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies each word against the running column and line
  // phase, so the back only carries out what the command tells it.
  logic        cmd_push;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  logic        cmd_pop;
  cmdq_stat_t  cmd_stat;
  front_stat_t front_stat;

  bb3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .line_width (line_width_r),
    .q_stat     (cmd_stat),
    .q_push     (cmd_push),
    .q_cmd      (cmd_in),
    .stat       (front_stat)
  );

  // The command queue lets the front keep accepting while the back waits
  // on a stalled output, and the back keep draining while input idles.
  bb3_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .stat     (cmd_stat)
  );

  // The back reads the line store when it pops a command, then adds the
  // 3x3 window, then scales and queues the results.
  bb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!cmd_stat.empty),
    .q_head    (cmd_head),
    .q_pop     (cmd_pop),
    .normalize (normalize_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An end-of-stream word returns the front to column zero of line zero.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.stream_end) |=>
      (front_stat.col == '0) && (front_stat.phase == PH_LINE0))
    else $error("front did not restart after end of stream");

  // A pixel word either advances the column by one or wraps it to zero.
  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.stream_end) |=>
      (front_stat.col == '0) ||
      (front_stat.col == $past(front_stat.col) + COL_W'(1)))
    else $error("column count skipped");

  // The command queue is never written while full.
  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_stat.full)
    else $error("command queue overflow");

  // The back never pops an empty command queue.
  a_cmdq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_stat.empty)
    else $error("command queue underflow");

endmodule

`default_nettype wire

@@ rtl/bb3_front.sv @@
// Front of the box blur: accepts input words and classifies them.
// Tracks column and line phase and pushes commands into the command queue.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bb3_pkg::in_t                 in_data,
  input  logic [bb3_pkg::WIDTH_W-1:0]  line_width,
  input  bb3_pkg::cmdq_stat_t          q_stat,
  output logic                         q_push,
  output bb3_pkg::cmd_t                q_cmd,
  output bb3_pkg::front_stat_t         stat
);
  import bb3_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  phase_t           phase_r, phase_nxt;
  logic [W_W-1:0]   w_use;
  logic             last;
  logic             accept;

  // Width in use, clamped to the range the line store supports.
  always_comb begin
    if (line_width < MIN_WIDTH) begin
      w_use = W_W'(MIN_WIDTH);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      w_use = W_W'(MAX_WIDTH);
    end else begin
      w_use = W_W'(line_width);
    end
  end

  assign last     = (W_W'(col_r) + W_W'(1)) >= w_use;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;

  always_comb begin
    q_cmd.is_end = in_data.stream_end;
    q_cmd.pix    = in_data.pixel_in;
    q_cmd.col    = col_r;
    q_cmd.emit_a = (phase_r != PH_LINE0) && (col_r != '0);
    q_cmd.a_sum  = (phase_r == PH_STEADY) && (col_r >= COL_W'(2));
    q_cmd.emit_b = (phase_r != PH_LINE0) && last;
  end

  always_comb begin
    col_nxt   = col_r;
    phase_nxt = phase_r;
    if (accept) begin
      priority if (in_data.stream_end) begin
        col_nxt   = '0;
        phase_nxt = PH_LINE0;
      end else if (last) begin
        col_nxt = '0;
        unique case (phase_r)
          PH_LINE0:  phase_nxt = PH_LINE1;
          PH_LINE1:  phase_nxt = PH_STEADY;
          PH_STEADY: phase_nxt = PH_STEADY;
          default:   phase_nxt = PH_LINE0;
        endcase
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      phase_r <= PH_LINE0;
    end else begin
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign stat.col   = col_r;
  assign stat.phase = phase_r;

endmodule

`default_nettype wire

@@ rtl/bb3_cmd_queue.sv @@
// Short command queue between the front and the back of the box blur.
// Register based, one push and one pop per cycle.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_cmd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bb3_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output bb3_pkg::cmd_t       head,
  output bb3_pkg::cmdq_stat_t stat
);
  import bb3_pkg::*;

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = slot_r[rd_r];
  assign stat.full  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_nxt  = push ? wr_r + CMDQ_PTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + CMDQ_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bb3_back.sv @@
// Back of the box blur: line store, 3x3 window, sum, scaling and result queue.
// Pops commands from the command queue and delivers result words.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bb3_pkg::cmd_t q_head,
  output logic          q_pop,
  input  logic          normalize,
  output logic          out_valid,
  input  logic          out_stall,
  output bb3_pkg::out_t out_data
);
  import bb3_pkg::*;

  // Line store: low byte is the previous line, high byte the one before.
  logic [LS_W-1:0]  line_store [MAX_WIDTH];

  // Stage one: command plus the registered line store read.
  logic             b1_v_r;
  cmd_t             b1_cmd_r;
  logic [LS_W-1:0]  b1_rd_r;
  logic             b1_move;

  // Window: entries 0..2 column c-2, 3..5 column c-1, rows oldest first.
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] old1, old2;
  logic [SUM_W-1:0] sum;

  // Stage two: sum and emit flags.
  logic             b2_v_r;
  exec_t            b2_r;
  logic             b2_push;
  logic [1:0]       b2_n;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0] value;
  out_t             res0, res1;

  // Result queue.
  out_t                  oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_CNT_W-1:0] oq_cnt_r;
  logic [1:0]            n_eff;
  logic                  out_pop;
  logic                  room;

  assign old1 = b1_rd_r[PIX_W-1:0];
  assign old2 = b1_rd_r[LS_W-1:PIX_W];

  assign b1_move = b1_v_r && (!b2_v_r || b2_push);
  assign q_pop   = q_valid && (!b1_v_r || b1_move);

  always_comb begin
    sum = SUM_W'(old2) + SUM_W'(old1) + SUM_W'(b1_cmd_r.pix);
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(win_r[i]);
    end
  end

  // Line store write and read. Items pass stage one in order, so a read
  // never races a pending write to the same column.
  always_ff @(posedge clk) begin
    if (b1_move && !b1_cmd_r.is_end) begin
      line_store[b1_cmd_r.col] <= {old1, b1_cmd_r.pix};
    end
    if (q_pop) begin
      b1_rd_r  <= line_store[q_head.col];
      b1_cmd_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (b1_move) begin
      if (b1_cmd_r.is_end) begin
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= old2;
        win_r[4] <= old1;
        win_r[5] <= b1_cmd_r.pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      b2_r.is_end <= b1_cmd_r.is_end;
      b2_r.emit_a <= b1_cmd_r.emit_a;
      b2_r.a_sum  <= b1_cmd_r.a_sum;
      b2_r.emit_b <= b1_cmd_r.emit_b;
      b2_r.sum    <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b1_v_r <= 1'b1;
      end else if (b1_move) begin
        b1_v_r <= 1'b0;
      end
      if (b1_move) begin
        b2_v_r <= 1'b1;
      end else if (b2_push) begin
        b2_v_r <= 1'b0;
      end
    end
  end

  // Scaling: divide by nine through the reciprocal, or saturate.
  assign prod = PROD_W'(b2_r.sum) * PROD_W'(DIV9_RECIP);

  always_comb begin
    if (!b2_r.a_sum) begin
      value = '0;
    end else if (normalize) begin
      value = prod[DIV9_SHIFT +: PIX_W];
    end else if (b2_r.sum > SUM_W'(PIX_MAX)) begin
      value = PIX_MAX;
    end else begin
      value = b2_r.sum[PIX_W-1:0];
    end
  end

  always_comb begin
    res0.pixel_out      = '0;
    res0.line_end       = 1'b0;
    res0.stream_end_out = 1'b0;
    res1.pixel_out      = '0;
    res1.line_end       = 1'b1;
    res1.stream_end_out = 1'b0;
    priority if (b2_r.is_end) begin
      res0.stream_end_out = 1'b1;
      b2_n = 2'd1;
    end else if (b2_r.emit_a) begin
      res0.pixel_out = value;
      b2_n = b2_r.emit_b ? 2'd2 : 2'd1;
    end else begin
      res0.line_end = b2_r.emit_b;
      b2_n = b2_r.emit_b ? 2'd1 : 2'd0;
    end
  end

  assign room    = (OUTQ_CNT_W+1)'(oq_cnt_r) + (OUTQ_CNT_W+1)'(b2_n)
                   <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
  assign b2_push = b2_v_r && room;
  assign n_eff   = b2_push ? b2_n : 2'd0;

  assign out_valid = (oq_cnt_r != '0);
  assign out_data  = oq_r[oq_rd_r];
  assign out_pop   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (n_eff != 2'd0) begin
      oq_r[oq_wr_r] <= res0;
    end
    if (n_eff == 2'd2) begin
      oq_r[oq_wr_r + OUTQ_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_r + OUTQ_PTR_W'(n_eff);
      oq_rd_r  <= oq_rd_r + OUTQ_PTR_W'(out_pop);
      oq_cnt_r <= oq_cnt_r + OUTQ_CNT_W'(n_eff) - OUTQ_CNT_W'(out_pop);
    end
  end

endmodule

`default_nettype wire
